[hdl/mcab_pkg.sv]
// Shared types, constants and pixel functions for the mip chain blend reducer.
// Used by mcab_level_ctx and mip_chain_alpha_blend_reducer. No dependencies.
`default_nettype none

package mcab_pkg;

  localparam int MAX_DIM_LOG2 = 10;
  localparam int MIP_LEVELS   = 5;
  localparam int SRC_LEVELS   = MIP_LEVELS - 1;

  localparam int DIM_W   = MAX_DIM_LOG2;            // column / row counter width
  localparam int DIM1_W  = DIM_W + 1;
  localparam int POS_W   = DIM_W - 1;               // position in produced level
  localparam int LG_W    = 4;                       // dimension register width
  localparam int LVL_W   = (SRC_LEVELS > 1) ? $clog2(SRC_LEVELS) : 1;
  localparam int OLVL_W  = 3;                       // mip_level field width
  localparam int PIX_W   = 32;
  localparam int PACK_W  = 25;

  localparam int STORE_DEPTH = 1 << MAX_DIM_LOG2;
  localparam int ADDR_W      = MAX_DIM_LOG2;

  localparam logic [LVL_W-1:0]  LVL_LAST  = LVL_W'(SRC_LEVELS - 1);
  localparam logic [PIX_W-1:0]  ALPHA_ON  = 32'hff00_0000;
  localparam logic [PIX_W-1:0]  RGB_MASK  = 32'h00ff_ffff;
  localparam logic [8:0]        ALPHA_MIN = 9'd255;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH_LOG2,
    CFG_HEIGHT_LOG2,
    CFG_GEN_ENABLE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MIX_AVG,
    MIX_FIRST,
    MIX_SECOND
  } mix_e;

  // per-level counter/hold update request from the step stage
  typedef struct packed {
    logic adv;   // advance the level's column/row counters
    logic keep;  // capture the texel as the level's even-column hold
  } step_t;

  // per-level context seen by the step stage
  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [PIX_W-1:0] left;
    logic             nxt_odd;  // next level sits at odd column and odd row
  } ctx_t;

  function automatic logic [PIX_W-1:0] crisp_pair(input logic [PIX_W-1:0] c0,
                                                  input logic [PIX_W-1:0] c1);
    logic [8:0]       asum;
    mix_e             mode;
    logic [7:0]       x0;
    logic [7:0]       x1;
    logic [8:0]       avg;
    logic [15:0]      wsum;
    logic [PIX_W-1:0] res;
    asum = {1'b0, c0[31:24]} + {1'b0, c1[31:24]};
    res  = '0;
    if (asum < ALPHA_MIN) begin
      mode = MIX_AVG;
    end else if (c0[31:24] > c1[31:24]) begin
      mode = MIX_FIRST;
    end else begin
      mode = MIX_SECOND;
    end
    for (int k = 0; k < 3; k++) begin
      x0   = c0[8*k +: 8];
      x1   = c1[8*k +: 8];
      avg  = {1'b0, x0} + {1'b0, x1};
      wsum = '0;
      case (mode)
        MIX_AVG: begin
          res[8*k +: 8] = avg[8:1];
        end
        MIX_FIRST: begin
          wsum = {x0, 8'd0} - {8'd0, x0} + {8'd0, x1};
          res[8*k +: 8] = wsum[15:8];
        end
        MIX_SECOND: begin
          wsum = {x1, 8'd0} - {8'd0, x1} + {8'd0, x0};
          res[8*k +: 8] = wsum[15:8];
        end
        default: begin
          res[8*k +: 8] = avg[8:1];
        end
      endcase
    end
    if (mode != MIX_AVG) begin
      res = res | ALPHA_ON;
    end
    return res;
  endfunction

  function automatic logic [PACK_W-1:0] pack25(input logic [PIX_W-1:0] c);
    return {(c[31:24] != 8'd0), c[23:0]};
  endfunction

  function automatic logic [PIX_W-1:0] unpack25(input logic [PACK_W-1:0] p);
    return ({8'd0, p[23:0]} & RGB_MASK) | (p[24] ? ALPHA_ON : '0);
  endfunction

  // line store region of produced level lvl+1, offset by column pair
  function automatic logic [ADDR_W-1:0] store_index(input logic [LVL_W-1:0] lvl,
                                                    input logic [POS_W-1:0] xo);
    logic [ADDR_W:0] depth_v;
    logic [ADDR_W:0] base;
    logic [ADDR_W:0] size;
    logic [ADDR_W:0] mask;
    depth_v = (ADDR_W+1)'(STORE_DEPTH);
    base    = depth_v - (depth_v >> lvl);
    size    = (depth_v >> lvl) >> 1;
    mask    = (size == '0) ? '0 : size - 1'b1;
    return ADDR_W'(base + ({2'b00, xo} & mask));
  endfunction

  // level dimension minus one, dimension saturated at MAX_DIM_LOG2
  function automatic logic [DIM_W-1:0] dim_mask(input logic [LG_W-1:0] lg,
                                                input logic [LVL_W-1:0] lvl);
    logic [LG_W-1:0]   l;
    logic [DIM1_W-1:0] one;
    l = (lg > LG_W'(MAX_DIM_LOG2)) ? LG_W'(MAX_DIM_LOG2) : lg;
    if (l >= LG_W'(lvl)) begin
      one = DIM1_W'(1) << (l - LG_W'(lvl));
    end else begin
      one = DIM1_W'(1);
    end
    return DIM_W'(one - 1'b1);
  endfunction

endpackage

`default_nettype wire

[hdl/mcab_store_ram.sv]
// Generic single-port synchronous RAM with registered read.
// Holds the blended top pairs; no package dependency.
`default_nettype none

module mcab_store_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/mcab_level_ctx.sv]
// Per-source-level column/row counters and even-column texel holds.
// Depends on mcab_pkg.
`default_nettype none

module mcab_level_ctx (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic [mcab_pkg::LG_W-1:0]    width_log2_i,
  input  logic [mcab_pkg::LG_W-1:0]    height_log2_i,
  input  logic [mcab_pkg::LVL_W-1:0]   lvl_i,
  input  mcab_pkg::step_t              step_i,
  input  logic [mcab_pkg::PIX_W-1:0]   texel_i,
  output mcab_pkg::ctx_t               ctx_o
);

  logic [mcab_pkg::DIM_W-1:0] col_q  [mcab_pkg::SRC_LEVELS];
  logic [mcab_pkg::DIM_W-1:0] row_q  [mcab_pkg::SRC_LEVELS];
  logic [mcab_pkg::PIX_W-1:0] left_q [mcab_pkg::SRC_LEVELS];
  logic [mcab_pkg::SRC_LEVELS-1:0] odd_vec;

  logic [mcab_pkg::DIM_W-1:0] cur_x;
  logic [mcab_pkg::DIM_W-1:0] cur_y;
  logic [mcab_pkg::DIM_W-1:0] col_d;
  logic [mcab_pkg::DIM_W-1:0] row_d;
  logic                       x_last;
  logic                       y_last;

  assign cur_x  = col_q[lvl_i];
  assign cur_y  = row_q[lvl_i];
  assign x_last = cur_x >= mcab_pkg::dim_mask(width_log2_i, lvl_i);
  assign y_last = cur_y >= mcab_pkg::dim_mask(height_log2_i, lvl_i);

  always_comb begin
    col_d = cur_x + 1'b1;
    row_d = cur_y;
    if (x_last) begin
      col_d = '0;
      row_d = y_last ? '0 : cur_y + 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < mcab_pkg::SRC_LEVELS; k++) begin
      odd_vec[k] = col_q[k][0] & row_q[k][0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mcab_pkg::SRC_LEVELS; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else if (clr_i) begin
      for (int k = 0; k < mcab_pkg::SRC_LEVELS; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else if (step_i.adv) begin
      for (int k = 0; k < mcab_pkg::SRC_LEVELS; k++) begin
        if (lvl_i == mcab_pkg::LVL_W'(k)) begin
          col_q[k] <= col_d;
          row_q[k] <= row_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < mcab_pkg::SRC_LEVELS; k++) begin
      if (step_i.keep && lvl_i == mcab_pkg::LVL_W'(k)) begin
        left_q[k] <= texel_i;
      end
    end
  end

  always_comb begin
    ctx_o.col     = cur_x;
    ctx_o.row     = cur_y;
    ctx_o.left    = left_q[lvl_i];
    ctx_o.nxt_odd = 1'b0;
    if (lvl_i != mcab_pkg::LVL_LAST) begin
      ctx_o.nxt_odd = odd_vec[lvl_i + 1'b1];
    end
  end

endmodule

`default_nettype wire

[hdl/mip_chain_alpha_blend_reducer.sv]
// Top level of the mip chain blend reducer: step stage, blend stage, output register.
// Depends on mcab_pkg, mcab_level_ctx and mcab_store_ram.
//
// Usage:
//  - Slave stream takes level-0 ARGB texels in raster order, one request per texel.
//  - Master stream returns texels of levels 1..4; tuser carries the level, tlast marks
//    the last result caused by one input texel.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_data_i): 0 width_log2, 1 height_log2,
//    2 generate_enable. Write only while idle; a dimension write restarts the image.
//  - Texels that finish no 2x2 block stream back to back while the master side does not stall.
//  - Each produced level takes a line-store read in the step stage, then the final
//    blend in the blend stage, which feeds the result back as the next level's
//    input. New input is held off while such a cascade is in flight.
//  - First result passes the step, blend and output registers before it is
//    presented on the master side.
//  - Line store: one 1024 x 25 single-port RAM; each step does a read, a write or
//    neither, never both, so no forwarding is needed.
//  - Reset clears counters, pipeline valids and config to 16x16 with generation on.
//    The line store is not cleared; every entry is written before it is read.
//  - A stalled master side holds the output register, then the blend stage, then the
//    step stage; tready drops as the stall reaches the input.
`default_nettype none

module mip_chain_alpha_blend_reducer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  // input texels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] texel_argb
  // produced texels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [8:0] pos_x, [17:9] pos_y, [49:18] out_argb
  output logic [2:0]  m_axis_tuser,   // [2:0] mip_level
  output logic        m_axis_tlast    // run_last
);

  localparam logic [mcab_pkg::LG_W-1:0] LG_RESET = 4'd4;

  // config
  logic [mcab_pkg::LG_W-1:0] width_log2_q;
  logic [mcab_pkg::LG_W-1:0] height_log2_q;
  logic                      gen_en_q;
  logic                      dim_clr;

  // step stage input register
  logic                        step_valid_q, step_valid_d;
  logic [mcab_pkg::LVL_W-1:0]  step_lvl_q, step_lvl_d;
  logic [mcab_pkg::PIX_W-1:0]  step_cur_q, step_cur_d;

  // blend stage register
  logic                        b_valid_q;
  logic                        b_emit_q;
  logic                        b_cont_q;
  logic                        b_last_q;
  logic [mcab_pkg::LVL_W-1:0]  b_lvl_q;
  logic [mcab_pkg::POS_W-1:0]  b_px_q;
  logic [mcab_pkg::POS_W-1:0]  b_py_q;
  logic [mcab_pkg::PIX_W-1:0]  b_bot_q;

  // output register
  logic                        out_valid_q;
  logic [mcab_pkg::OLVL_W-1:0] out_lvl_q;
  logic [mcab_pkg::POS_W-1:0]  out_px_q;
  logic [mcab_pkg::POS_W-1:0]  out_py_q;
  logic [mcab_pkg::PIX_W-1:0]  out_argb_q;
  logic                        out_last_q;

  mcab_pkg::ctx_t  ctx;
  mcab_pkg::step_t step_req;

  logic                         out_free;
  logic                         b_adv;
  logic                         b_free;
  logic                         a_fire;
  logic                         a_emit;
  logic                         a_cont;
  logic                         mem_re;
  logic                         mem_we;
  logic [mcab_pkg::ADDR_W-1:0]  mem_addr;
  logic [mcab_pkg::PACK_W-1:0]  mem_wdata;
  logic [mcab_pkg::PACK_W-1:0]  mem_rdata;
  logic [mcab_pkg::PIX_W-1:0]   a_bot;
  logic [mcab_pkg::PIX_W-1:0]   b_res;
  logic                         in_acc;
  logic                         fb_load;

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= LG_RESET;
      height_log2_q <= LG_RESET;
      gen_en_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcab_pkg::CFG_WIDTH_LOG2:  width_log2_q  <= cfg_data_i;
        mcab_pkg::CFG_HEIGHT_LOG2: height_log2_q <= cfg_data_i;
        mcab_pkg::CFG_GEN_ENABLE:  gen_en_q      <= cfg_data_i[0];
        default:                   ;
      endcase
    end
  end

  assign dim_clr = cfg_we_i &&
                   (cfg_idx_i == mcab_pkg::CFG_WIDTH_LOG2 ||
                    cfg_idx_i == mcab_pkg::CFG_HEIGHT_LOG2);

  // ---------------- handshake / flow ----------------
  assign out_free = !out_valid_q || m_axis_tready;
  assign b_adv    = b_valid_q && (!b_emit_q || out_free);
  assign b_free   = !b_valid_q || b_adv;
  assign a_fire   = step_valid_q && b_free;

  // odd column and odd row completes a 2x2 block at this level
  assign a_emit = ctx.col[0] && ctx.row[0];
  assign a_cont = step_valid_q && a_emit && (step_lvl_q != mcab_pkg::LVL_LAST);

  // hold input off while a cascade result is on its way back to the step stage
  assign s_axis_tready = (!step_valid_q || a_fire) && !(a_fire && a_cont) &&
                         !(b_valid_q && b_cont_q);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign fb_load = b_adv && b_cont_q;

  // ---------------- step stage ----------------
  assign step_req.adv  = a_fire;
  assign step_req.keep = a_fire && !ctx.col[0];

  mcab_level_ctx u_ctx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clr_i         (dim_clr),
    .width_log2_i  (width_log2_q),
    .height_log2_i (height_log2_q),
    .lvl_i         (step_lvl_q),
    .step_i        (step_req),
    .texel_i       (step_cur_q),
    .ctx_o         (ctx)
  );

  assign mem_re    = a_fire && ctx.col[0] && ctx.row[0];
  assign mem_we    = a_fire && ctx.col[0] && !ctx.row[0];
  assign mem_addr  = mcab_pkg::store_index(step_lvl_q,
                                           ctx.col[mcab_pkg::DIM_W-1:1]);
  assign mem_wdata = mcab_pkg::pack25(mcab_pkg::crisp_pair(ctx.left, step_cur_q));
  assign a_bot     = mcab_pkg::crisp_pair(step_cur_q, ctx.left);

  mcab_store_ram #(
    .DEPTH (mcab_pkg::STORE_DEPTH),
    .WIDTH (mcab_pkg::PACK_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    step_valid_d = step_valid_q;
    step_lvl_d   = step_lvl_q;
    step_cur_d   = step_cur_q;
    if (a_fire) begin
      step_valid_d = 1'b0;
    end
    if (fb_load) begin
      step_valid_d = 1'b1;
      step_lvl_d   = b_lvl_q + 1'b1;
      step_cur_d   = b_res;
    end else if (in_acc && gen_en_q) begin
      step_valid_d = 1'b1;
      step_lvl_d   = '0;
      step_cur_d   = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_valid_q <= 1'b0;
    end else begin
      step_valid_q <= step_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_lvl_q <= step_lvl_d;
    step_cur_q <= step_cur_d;
  end

  // ---------------- blend stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
      b_cont_q  <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_fire;
      b_emit_q  <= a_fire && a_emit;
      b_cont_q  <= a_fire && a_cont;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_lvl_q  <= step_lvl_q;
      b_px_q   <= ctx.col[mcab_pkg::DIM_W-1:1];
      b_py_q   <= ctx.row[mcab_pkg::DIM_W-1:1];
      b_bot_q  <= a_bot;
      // last unless the next level completes a block as well
      b_last_q <= !(a_cont && ctx.nxt_odd);
    end
  end

  assign b_res = mcab_pkg::crisp_pair(mcab_pkg::unpack25(mem_rdata), b_bot_q);

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_valid_q && b_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_emit_q) begin
      out_lvl_q  <= mcab_pkg::OLVL_W'(b_lvl_q) + 1'b1;
      out_px_q   <= b_px_q;
      out_py_q   <= b_py_q;
      out_argb_q <= b_res;
      out_last_q <= b_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_argb_q, out_py_q, out_px_q};
  assign m_axis_tuser  = out_lvl_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // a pending cascade leaves the step register empty
  a_cascade_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_valid_q && b_valid_q && b_cont_q))
    else $error("step register busy while cascade result pending");

  // single-port line store: one access per cycle
  a_store_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("line store read and write in same cycle");

  // a cascade result reenters the step stage on the next cycle
  a_cascade_reenters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_load |=> step_valid_q)
    else $error("cascade result lost");

  // produced levels lie in 1..SRC_LEVELS
  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 3'd0 &&
                       m_axis_tuser <= mcab_pkg::OLVL_W'(mcab_pkg::SRC_LEVELS)))
    else $error("mip level out of range");
`endif

endmodule

`default_nettype wire
